// ===== rtl/core/uvs_pkg.sv =====
// ----------------------------------------------------------------------------
// UV sphere tessellator package
// Shared types, register indexes, corner offsets and the quarter-wave sine.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam logic CSR_RADIUS    = 1'b0;
   localparam logic CSR_DIVISIONS = 1'b1;

   localparam logic [2:0] CORNER_LAST = 3'd5;

   typedef struct packed {
      logic [2:0] corner;
      logic       last;
      logic       oor;
   } meta_type;

   // Azimuth offset of each corner: 0 1 1 0 0 1
   function automatic logic corner_da(input logic [2:0] c);
      logic d;
      case (c)
         3'd1, 3'd2, 3'd5: d = 1'b1;
         default:          d = 1'b0;
      endcase
      return d;
   endfunction

   // Polar offset of each corner: 1 0 1 1 0 0
   function automatic logic corner_db(input logic [2:0] c);
      logic d;
      case (c)
         3'd0, 3'd2, 3'd3: d = 1'b1;
         default:          d = 1'b0;
      endcase
      return d;
   endfunction

   // Elaboration-time table builder: Taylor series in Q30, rounded to Q1.14.
   function automatic logic [14:0] quarter_sine(input int unsigned s, input int unsigned pb);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint          sum;
      x   = (longint'(s) * 64'd1686629713) >> (pb - 2);
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 156; sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 210; sum = sum - longint'(t);
      if (sum < 0) sum = 0;
      sum = (sum + 64'sd32768) >>> 16;
      if (sum > 16384) sum = 16384;
      return sum[14:0];
   endfunction

endpackage

// ===== rtl/core/uvs_recip.sv =====
// ----------------------------------------------------------------------------
// Reciprocal unit
// Bit-serial restoring divide: recip = floor(2^RW / divisor), one bit a cycle.
// ----------------------------------------------------------------------------
module uvs_recip
   import uvs_pkg::*;
#(
   parameter int RW = 20
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [9:0]    divisor,
   output logic          busy,
   output logic [RW-1:0] recip
);
   localparam int CW = $clog2(RW + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [9:0]    rem_ff, rem_in;
   logic [RW-1:0] quo_ff, quo_in;
   logic [10:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(RW);
         rem_in  = 10'd1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = 10'(trial - {1'b0, divisor});
            quo_in = {quo_ff[RW-2:0], 1'b1};
         end else begin
            rem_in = trial[9:0];
            quo_in = {quo_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(RW);
         rem_ff  <= 10'd1;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         rem_ff  <= rem_in;
      end
      quo_ff <= quo_in;
   end

   assign busy  = busy_ff;
   assign recip = quo_ff;

endmodule

// ===== rtl/core/uv_sphere_cell_tessellator.sv =====
// ----------------------------------------------------------------------------
// UV sphere cell tessellator
// One grid cell in, six triangle vertices out (position Q8.8, normal Q1.14).
// ----------------------------------------------------------------------------
// Path: the first vertex of a cell leaves the sequencer, then the 8-stage vertex pipeline.
// Throughput: one vertex per cycle unless rsp_ready holds the output; the vertex
//   sequencer takes a new cell as it issues the last of six, the pipeline takes one a cycle.
// Reset: sync, active high; registers go to radius 1.0 and 16 divisions.
//   After reset and after each division_count write, req_ready stays low
//   while the serial unit forms 1/(2N).
module uv_sphere_cell_tessellator
   import uvs_pkg::*;
#(
   parameter int PHASE_BITS    = 10,
   parameter int MAX_DIVISIONS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_stack_index,
   input  logic [7:0]         req_slice_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [2:0]         rsp_corner,
   output logic               rsp_last,
   output logic               rsp_out_of_range,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);
   localparam int P       = PHASE_BITS;
   localparam int QUARTER = 1 << (P - 2);
   localparam int NUMW    = P + 10;   // numerator: a*2^(P+1) + N, a <= 256
   localparam int NE_CAP  = (MAX_DIVISIONS > 511) ? 511 : MAX_DIVISIONS;

   // ---------------- config registers ----------------
   logic [15:0] radius_ff;
   logic [8:0]  divs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 16'd256;
         divs_ff   <= 9'd16;
      end else if (csr_write) begin
         if (csr_index == CSR_RADIUS)    radius_ff <= csr_wdata;
         if (csr_index == CSR_DIVISIONS) divs_ff   <= csr_wdata[8:0];
      end
   end

   // Clamped division count for the angle math
   logic [8:0] ne;
   logic [9:0] dvs;   // 2*N

   always_comb begin
      if (divs_ff == 9'd0)                   ne = 9'd1;
      else if (int'(divs_ff) > NE_CAP)       ne = NE_CAP[8:0];
      else                                   ne = divs_ff;
      dvs = {ne, 1'b0};
   end

   logic            recip_busy;
   logic [NUMW-1:0] recip;

   uvs_recip #(.RW(NUMW)) u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_write && csr_index == CSR_DIVISIONS),
      .divisor (dvs),
      .busy    (recip_busy),
      .recip   (recip)
   );

   // Global advance: the whole pipeline moves unless the output is blocked.
   logic en;
   logic out_valid_ff;
   assign en = rsp_ready || !out_valid_ff;

   // ---------------- cell sequencer ----------------
   logic       seq_valid_ff;
   logic [7:0] seq_i_ff, seq_j_ff;
   logic       seq_oor_ff;
   logic [2:0] seq_corner_ff;
   logic       issue, accept;

   assign issue     = seq_valid_ff && en;
   assign req_ready = !recip_busy &&
                      (!seq_valid_ff || (issue && seq_corner_ff == CORNER_LAST));
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_valid_ff  <= 1'b0;
         seq_corner_ff <= 3'd0;
      end else if (accept) begin
         seq_valid_ff  <= 1'b1;
         seq_corner_ff <= 3'd0;
      end else if (issue) begin
         if (seq_corner_ff == CORNER_LAST) seq_valid_ff <= 1'b0;
         seq_corner_ff <= seq_corner_ff + 3'd1;
      end
      if (accept) begin
         seq_i_ff   <= req_stack_index;
         seq_j_ff   <= req_slice_index;
         seq_oor_ff <= ({1'b0, req_stack_index} >= divs_ff) ||
                       ({1'b0, req_slice_index} >= divs_ff);
      end
   end

   // ---------------- stage 0: phase numerators ----------------
   logic            v0_ff;
   meta_type        m0_ff;
   logic [NUMW-1:0] na0_ff, np0_ff;
   logic [8:0]      va, vb;

   assign va = {1'b0, seq_i_ff} + {8'd0, corner_da(seq_corner_ff)};
   assign vb = {1'b0, seq_j_ff} + {8'd0, corner_db(seq_corner_ff)};

   // ---------------- stage 1: q0 = num * recip >> NUMW ----------------
   logic            v1_ff;
   meta_type        m1_ff;
   logic [NUMW-1:0] na1_ff, np1_ff, qa1_ff, qp1_ff;
   logic [2*NUMW-1:0] pa1, pp1;

   assign pa1 = na0_ff * recip;
   assign pp1 = np0_ff * recip;

   // ---------------- stage 2: q0 * 2N ----------------
   logic              v2_ff;
   meta_type          m2_ff;
   logic [NUMW-1:0]   na2_ff, np2_ff, qa2_ff, qp2_ff;
   logic [NUMW+9:0]   da2_ff, dp2_ff;

   // ---------------- stage 3: one-step correction, phases ----------------
   logic            v3_ff;
   meta_type        m3_ff;
   logic [P-1:0]    tp3_ff, pp3_ff;
   logic [NUMW-1:0] ra, rp;
   logic [NUMW-1:0] qa_fix, qp_fix;

   always_comb begin
      ra = na2_ff - da2_ff[NUMW-1:0];
      rp = np2_ff - dp2_ff[NUMW-1:0];
      qa_fix = (ra >= NUMW'(dvs)) ? qa2_ff + 1'b1 : qa2_ff;
      qp_fix = (rp >= NUMW'(dvs)) ? qp2_ff + 1'b1 : qp2_ff;
   end

   // ---------------- stage 4: sine table lookups ----------------
   logic [14:0] qsin_tab [QUARTER+1];
   for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
      assign qsin_tab[g] = quarter_sine(g, P);
   end

   logic               v4_ff;
   meta_type           m4_ff;
   logic signed [15:0] trig4_ff [4];   // sin T, cos T, sin P, cos P
   logic [P-1:0]       ph [4];
   logic signed [15:0] trig [4];

   always_comb begin
      logic [1:0]   quad;
      logic [P-2:0] s;
      logic [14:0]  mag;
      ph[0] = tp3_ff;
      ph[1] = tp3_ff + P'(QUARTER);
      ph[2] = pp3_ff;
      ph[3] = pp3_ff + P'(QUARTER);
      for (int k = 0; k < 4; k++) begin
         quad = ph[k][P-1:P-2];
         s    = {1'b0, ph[k][P-3:0]};
         if (quad[0]) s = QUARTER[P-2:0] - s;
         mag  = qsin_tab[s];
         trig[k] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   // ---------------- stage 5: unit vector, x and z in Q2.28, y in Q1.14 ----------------
   logic               v5_ff;
   meta_type           m5_ff;
   logic signed [30:0] vx5_ff, vz5_ff;
   logic signed [15:0] vy5_ff;
   logic signed [31:0] ctsp, stsp;

   assign ctsp = trig4_ff[1] * trig4_ff[2];
   assign stsp = trig4_ff[0] * trig4_ff[2];

   // ---------------- stage 6: normals, radius products ----------------
   function automatic logic signed [15:0] rnd14_31(input logic signed [30:0] v);
      logic [30:0] m;
      m = v[30] ? 31'(-v) : v;
      m = (m + 31'd8192) >> 14;
      return v[30] ? 16'(-m) : 16'(m);
   endfunction

   function automatic logic signed [16:0] rnd28_48(input logic signed [47:0] v);
      logic [47:0] m;
      m = v[47] ? 48'(-v) : v;
      m = (m + 48'd134217728) >> 28;
      return v[47] ? 17'(-m) : 17'(m);
   endfunction

   function automatic logic signed [16:0] rnd14_33(input logic signed [32:0] v);
      logic [32:0] m;
      m = v[32] ? 33'(-v) : v;
      m = (m + 33'd8192) >> 14;
      return v[32] ? 17'(-m) : 17'(m);
   endfunction

   logic               v6_ff;
   meta_type           m6_ff;
   logic signed [15:0] nx6_ff, ny6_ff, nz6_ff;
   logic signed [47:0] px6_ff, pz6_ff;
   logic signed [32:0] py6_ff;
   logic signed [16:0] rad_s;

   assign rad_s = $signed({1'b0, radius_ff});

   // ---------------- stage 7: output register ----------------
   meta_type           mo_ff;
   logic signed [16:0] px_ff, py_ff, pz_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0; v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0;
         v4_ff <= 1'b0; v5_ff <= 1'b0; v6_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= issue;
         v1_ff <= v0_ff; v2_ff <= v1_ff; v3_ff <= v2_ff;
         v4_ff <= v3_ff; v5_ff <= v4_ff; v6_ff <= v5_ff;
         out_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m0_ff.corner <= seq_corner_ff;
         m0_ff.last   <= (seq_corner_ff == CORNER_LAST);
         m0_ff.oor    <= seq_oor_ff;
         na0_ff <= {va, (P + 1)'(0)} + NUMW'(ne);
         np0_ff <= NUMW'({vb, P'(0)}) + NUMW'(ne);

         m1_ff  <= m0_ff;
         na1_ff <= na0_ff;
         np1_ff <= np0_ff;
         qa1_ff <= pa1[2*NUMW-1:NUMW];
         qp1_ff <= pp1[2*NUMW-1:NUMW];

         m2_ff  <= m1_ff;
         na2_ff <= na1_ff;
         np2_ff <= np1_ff;
         qa2_ff <= qa1_ff;
         qp2_ff <= qp1_ff;
         da2_ff <= qa1_ff * dvs;
         dp2_ff <= qp1_ff * dvs;

         m3_ff  <= m2_ff;
         tp3_ff <= qa_fix[P-1:0];
         pp3_ff <= qp_fix[P-1:0];

         m4_ff  <= m3_ff;
         for (int k = 0; k < 4; k++) trig4_ff[k] <= trig[k];

         m5_ff  <= m4_ff;
         vx5_ff <= 31'(-ctsp);
         vz5_ff <= stsp[30:0];
         vy5_ff <= -trig4_ff[3];

         m6_ff  <= m5_ff;
         nx6_ff <= rnd14_31(vx5_ff);
         nz6_ff <= rnd14_31(vz5_ff);
         ny6_ff <= vy5_ff;
         px6_ff <= rad_s * vx5_ff;
         pz6_ff <= rad_s * vz5_ff;
         py6_ff <= rad_s * vy5_ff;

         mo_ff <= m6_ff;
         nx_ff <= nx6_ff;
         ny_ff <= ny6_ff;
         nz_ff <= nz6_ff;
         px_ff <= rnd28_48(px6_ff);
         pz_ff <= rnd28_48(pz6_ff);
         py_ff <= rnd14_33(py6_ff);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pos_x        = px_ff;
   assign rsp_pos_y        = py_ff;
   assign rsp_pos_z        = pz_ff;
   assign rsp_norm_x       = nx_ff;
   assign rsp_norm_y       = ny_ff;
   assign rsp_norm_z       = nz_ff;
   assign rsp_corner       = mo_ff.corner;
   assign rsp_last         = mo_ff.last;
   assign rsp_out_of_range = mo_ff.oor;

endmodule
